// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define FCFP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fcfp assertion failed");

// Check a property also while reset is held.
`define FCFP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("fcfp assertion failed");

`endif

// File: hdl/fcfp_pkg.sv
// Types and constants of the Fletcher-checked frame parser.
// No dependencies.
package fcfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam int HEADER_LEN  = 6;
    localparam int CHECK_LEN   = 2;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;   // holds MAX_RESULTS
    localparam int TOT_W       = 17;  // header + 16-bit length + check

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_HDR_ADDR  = 13'b0000000000010,
        ST_HDR_DATA  = 13'b0000000000100,
        ST_LEN       = 13'b0000000001000,
        ST_SUM_ADDR  = 13'b0000000010000,
        ST_SUM_DATA  = 13'b0000000100000,
        ST_CKA_ADDR  = 13'b0000001000000,
        ST_CKA_DATA  = 13'b0000010000000,
        ST_CKB_ADDR  = 13'b0000100000000,
        ST_CKB_DATA  = 13'b0001000000000,
        ST_PREP      = 13'b0010000000000,
        ST_EMIT_ADDR = 13'b0100000000000,
        ST_EMIT_DATA = 13'b1000000000000
    } state_t;

endpackage

// File: hdl/fcfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/fletcher_checked_frame_parser_unit.sv
// Top level of the Fletcher-checked frame parser.
// Depends on fcfp_pkg and fcfp_ram.
//
// Each received byte is appended to a circular byte store; a sequencer then
// walks the store through one RAM read port, with an address state and a data
// state per byte read: sync and header, Fletcher sum over class through
// payload, check pair, and payload gather with a prep state and a handshake
// per word. A byte that completes nothing returns the sequencer to idle while
// fewer than two bytes are held, with a partial header or with a full header
// of an incomplete frame, after dropping any leading byte that cannot start a
// frame. A byte that closes a frame packs its payload of length L into W
// words (W is 1 for an empty payload), each held until out_ready, and a
// dropped frame or a failed check adds a rescan from the next stored byte.
// in_ready is high only while the sequencer is idle and no result is waiting.
// No clearing pass is needed after reset.
module fletcher_checked_frame_parser_unit
    import fcfp_pkg::*;
#(
    parameter int STORE_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  message_class,
    output logic [7:0]  message_id,
    output logic [8:0]  payload_length,
    output logic [63:0] payload_word,
    output logic [3:0]  valid_bytes,
    output logic        last_word
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int FW = $clog2(STORE_BYTES + 1);
    localparam int SW = FW + 1;
    localparam logic [SW-1:0]    SB_S = SW'(STORE_BYTES);
    localparam logic [TOT_W-1:0] SB_T = TOT_W'(STORE_BYTES);

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [FW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SB_S)
        begin
            s = s - SB_S;
        end
        return s[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        hidx_reg, hidx_next;
    logic [7:0]        cls_reg, cls_next;
    logic [7:0]        id_reg, id_next;
    logic [15:0]       plen_reg, plen_next;
    logic [FW-1:0]     ci_reg, ci_next;
    logic [7:0]        ca_reg, ca_next;
    logic [7:0]        cb_reg, cb_next;
    logic [15:0]       rem_reg, rem_next;
    logic [FW-1:0]     pidx_reg, pidx_next;
    logic [3:0]        bcnt_reg, bcnt_next;
    logic [3:0]        nvalid_reg, nvalid_next;
    logic [63:0]       word_reg, word_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [FW-1:0]     rd_off;
    logic [7:0]        rd_data;

    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  words;
    logic [7:0]        ca_sum;

    fcfp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign ram_we    = in_valid && in_ready && (fill_reg != FW'(STORE_BYTES));
    assign ram_waddr = wrap_add(head_reg, fill_reg);
    assign ram_raddr = wrap_add(head_reg, rd_off);

    assign total  = TOT_W'(plen_reg) + TOT_W'(HEADER_LEN + CHECK_LEN);
    assign words  = (plen_reg == 16'd0) ? TOT_W'(1) : TOT_W'((TOT_W'(plen_reg) + 7) >> 3);
    assign ca_sum = ca_reg + rd_data;

    always_comb
    begin
        case (state_reg)
            ST_HDR_ADDR:  rd_off = FW'(hidx_reg);
            ST_EMIT_ADDR: rd_off = pidx_reg;
            default:      rd_off = ci_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        hidx_next      = hidx_reg;
        cls_next       = cls_reg;
        id_next        = id_reg;
        plen_next      = plen_reg;
        ci_next        = ci_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        rem_next       = rem_reg;
        pidx_next      = pidx_reg;
        bcnt_next      = bcnt_reg;
        nvalid_next    = nvalid_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (out_valid_reg)
                begin
                    if (out_ready)
                    begin
                        out_valid_next = 1'b0;
                        count_next     = count_reg + 1'b1;
                        if (last_reg)
                        begin
                            // drop the whole frame and rescan
                            head_next  = wrap_add(head_reg, FW'(total));
                            fill_next  = fill_reg - FW'(total);
                            hidx_next  = 3'd0;
                            state_next = ST_HDR_ADDR;
                        end
                        else
                        begin
                            state_next = ST_PREP;
                        end
                    end
                end
                else if (in_valid)
                begin
                    if (ram_we)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    count_next = '0;
                    hidx_next  = 3'd0;
                    state_next = ST_HDR_ADDR;
                end
            end
            ST_HDR_ADDR:
            begin
                if ((hidx_reg == 3'd0) && (fill_reg < FW'(2)))
                begin
                    state_next = ST_IDLE;
                end
                else if ((hidx_reg == 3'd2) && (fill_reg < FW'(HEADER_LEN)))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HDR_DATA;
                end
            end
            ST_HDR_DATA:
            begin
                hidx_next  = hidx_reg + 1'b1;
                state_next = ST_HDR_ADDR;
                case (hidx_reg)
                    3'd0:
                    begin
                        if (rd_data != SYNC_FIRST)
                        begin
                            head_next = wrap_add(head_reg, FW'(1));
                            fill_next = fill_reg - 1'b1;
                            hidx_next = 3'd0;
                        end
                    end
                    3'd1:
                    begin
                        if (rd_data != SYNC_SECOND)
                        begin
                            head_next = wrap_add(head_reg, FW'(1));
                            fill_next = fill_reg - 1'b1;
                            hidx_next = 3'd0;
                        end
                    end
                    3'd2: cls_next = rd_data;
                    3'd3: id_next = rd_data;
                    3'd4: plen_next[7:0] = rd_data;
                    default:
                    begin
                        plen_next[15:8] = rd_data;
                        state_next      = ST_LEN;
                    end
                endcase
            end
            ST_LEN:
            begin
                if (total > SB_T)
                begin
                    head_next  = wrap_add(head_reg, FW'(1));
                    fill_next  = fill_reg - 1'b1;
                    hidx_next  = 3'd0;
                    state_next = ST_HDR_ADDR;
                end
                else if (TOT_W'(fill_reg) < total)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ci_next    = FW'(2);
                    ca_next    = 8'd0;
                    cb_next    = 8'd0;
                    state_next = ST_SUM_ADDR;
                end
            end
            ST_SUM_ADDR:
            begin
                if (TOT_W'(ci_reg) == TOT_W'(plen_reg) + TOT_W'(HEADER_LEN))
                begin
                    state_next = ST_CKA_ADDR;
                end
                else
                begin
                    state_next = ST_SUM_DATA;
                end
            end
            ST_SUM_DATA:
            begin
                ca_next    = ca_sum;
                cb_next    = cb_reg + ca_sum;
                ci_next    = ci_reg + 1'b1;
                state_next = ST_SUM_ADDR;
            end
            ST_CKA_ADDR:
            begin
                state_next = ST_CKA_DATA;
            end
            ST_CKA_DATA:
            begin
                if (rd_data != ca_reg)
                begin
                    head_next  = wrap_add(head_reg, FW'(1));
                    fill_next  = fill_reg - 1'b1;
                    hidx_next  = 3'd0;
                    state_next = ST_HDR_ADDR;
                end
                else
                begin
                    ci_next    = ci_reg + 1'b1;
                    state_next = ST_CKB_ADDR;
                end
            end
            ST_CKB_ADDR:
            begin
                state_next = ST_CKB_DATA;
            end
            ST_CKB_DATA:
            begin
                if (rd_data != cb_reg)
                begin
                    head_next  = wrap_add(head_reg, FW'(1));
                    fill_next  = fill_reg - 1'b1;
                    hidx_next  = 3'd0;
                    state_next = ST_HDR_ADDR;
                end
                else if (TOT_W'(count_reg) + words > TOT_W'(MAX_RESULTS))
                begin
                    // hold the frame until the next input transfer
                    state_next = ST_IDLE;
                end
                else
                begin
                    pidx_next  = FW'(HEADER_LEN);
                    rem_next   = plen_reg;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (rem_reg > 16'd8)
                begin
                    nvalid_next = 4'd8;
                    rem_next    = rem_reg - 16'd8;
                    last_next   = 1'b0;
                end
                else
                begin
                    nvalid_next = rem_reg[3:0];
                    rem_next    = 16'd0;
                    last_next   = 1'b1;
                end
                word_next  = 64'd0;
                bcnt_next  = 4'd0;
                state_next = ST_EMIT_ADDR;
            end
            ST_EMIT_ADDR:
            begin
                if (bcnt_reg == nvalid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_DATA;
                end
            end
            ST_EMIT_DATA:
            begin
                word_next  = word_reg | (64'(rd_data) << {bcnt_reg[2:0], 3'b000});
                pidx_next  = pidx_reg + 1'b1;
                bcnt_next  = bcnt_reg + 1'b1;
                state_next = ST_EMIT_ADDR;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            hidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            hidx_reg      <= hidx_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        id_reg     <= id_next;
        plen_reg   <= plen_next;
        ci_reg     <= ci_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        rem_reg    <= rem_next;
        pidx_reg   <= pidx_next;
        bcnt_reg   <= bcnt_next;
        nvalid_reg <= nvalid_next;
        word_reg   <= word_next;
    end

    assign out_valid      = out_valid_reg;
    assign message_class  = cls_reg;
    assign message_id     = id_reg;
    assign payload_length = plen_reg[8:0];
    assign payload_word   = word_reg;
    assign valid_bytes    = nvalid_reg;
    assign last_word      = last_reg;

endmodule

// File: hdl/fcfp_checker.sv
// Port-level checker for the frame parser, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fcfp_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] payload_word,
    input logic [3:0]  valid_bytes,
    input logic        last_word
);

    `FCFP_ASSERT(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(payload_word)
            && $stable(valid_bytes) && $stable(last_word))
    `FCFP_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid))
    `FCFP_ASSERT(a_count_range, clk, rst_n, out_valid |-> valid_bytes <= 4'd8)
    `FCFP_ASSERT(a_full_inner, clk, rst_n, out_valid && !last_word |-> valid_bytes == 4'd8)
    `FCFP_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind fletcher_checked_frame_parser_unit fcfp_port_checker u_fcfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_word (payload_word),
    .valid_bytes  (valid_bytes),
    .last_word    (last_word)
);
